/* hw/rtl/tvdlfc_pkg.sv */
// Package with the item types and limiter codes of the TVD face coefficient block.
`default_nettype none

package tvdlfc_pkg;

    typedef struct packed {
        logic signed [31:0] face_flux;
        logic signed [31:0] cell_value;
        logic signed [31:0] neighbour_value;
        logic signed [31:0] cell_grad_proj;
        logic signed [31:0] neighbour_grad_proj;
    } face_t;

    typedef struct packed {
        logic signed [31:0] neighbour_coeff;
        logic signed [31:0] central_part;
    } coeff_t;

    localparam logic [2:0] MODE_SUPERBEE = 3'd0;
    localparam logic [2:0] MODE_MINMOD   = 3'd1;
    localparam logic [2:0] MODE_OSHER    = 3'd2;
    localparam logic [2:0] MODE_MUSCL    = 3'd3;
    localparam logic [2:0] MODE_CHARM    = 3'd4;

endpackage

`default_nettype wire

/* hw/rtl/tvd_limited_face_coefficients_top.sv */
// Top level of the TVD limited face coefficient pipeline.
//
//  Channel  | Ports                    | Handshake
//  ---------+--------------------------+------------------------------------
//  face in  | start, busy, face        | taken when start is high, busy low
//  result   | done, result             | one cycle strobe, no back pressure
//  config   | cfg_we, cfg_wdata        | written when cfg_we is high
//
// One item enters every cycle; busy stays low. Each item passes three
// pipelined divider chains (ratio, limiter quotient, charm second
// quotient) of 32+F, 34+F and 2F+3 stages plus five stages of input capture,
// ratio, limiting, multiplication and rounding. Reset clears the valid bits
// and the limiter mode. Nothing stalls: results leave with a strobe for one
// cycle.
`default_nettype none

module tvd_limited_face_coefficients_top #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire tvdlfc_pkg::face_t   face,
    output logic                     done,
    output tvdlfc_pkg::coeff_t       result,
    input  wire logic                cfg_we,
    input  wire logic [2:0]          cfg_wdata
);

    localparam int F   = FRAC_BITS;
    localparam int D1W = 32 + F;
    localparam int D2W = 34 + F;
    localparam int D3W = 2 * F + 3;
    localparam int PW  = F + 2;
    localparam int RW  = D1W + 2;
    localparam int MW  = 32 + PW + 1;
    localparam int SW  = MW - F - 1;

    localparam logic [31:0]         ONE32   = 32'd1 << F;
    localparam logic signed [RW-1:0] ONER   = RW'(1) << F;
    localparam logic [33:0]         THREE34 = 34'd3 << F;
    localparam logic signed [33:0]  ONE34   = 34'sd1 <<< F;
    localparam logic signed [33:0]  TWO34   = 34'sd2 <<< F;
    localparam logic [D3W-1:0]      THREE3  = D3W'(3) << F;
    localparam logic signed [PW:0]  TWOP    = (PW+1)'(2) << F;
    localparam logic signed [MW-1:0] RNDM   = (MW'(2) << F) - MW'(1);

    logic [2:0] mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= tvdlfc_pkg::MODE_SUPERBEE;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_wdata;
        end
    end

    assign busy = 1'b0;

    // Input register.
    tvdlfc_pkg::face_t in_reg;
    logic              in_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            in_reg <= face;
        end
    end

    // Upwind selection and magnitudes for the ratio division.
    logic signed [31:0] num_s;
    logic signed [32:0] den_s;
    logic [32:0]        num_ext;
    logic [33:0]        den_ext;
    logic [31:0]        num_mag;
    logic [32:0]        den_mag;
    logic               flux_pos;
    logic [D1W-1:0]     div1_dividend;
    logic [33:0]        div1_side;

    always_comb
    begin
        flux_pos = (in_reg.face_flux > 32'sd0);
        if (flux_pos)
        begin
            num_s = in_reg.neighbour_grad_proj;
            den_s = 33'(in_reg.cell_value) - 33'(in_reg.neighbour_value);
        end
        else
        begin
            num_s = in_reg.cell_grad_proj;
            den_s = 33'(in_reg.neighbour_value) - 33'(in_reg.cell_value);
        end
        num_ext       = {num_s[31], num_s};
        den_ext       = {den_s[32], den_s};
        num_mag       = num_s[31] ? 32'(-num_ext) : num_ext[31:0];
        den_mag       = den_s[32] ? 33'(-den_ext) : den_ext[32:0];
        div1_dividend = {num_mag, {F{1'b0}}};
        div1_side     = {in_reg.face_flux, num_s[31] ^ den_s[32], den_s == 33'sd0};
    end

    logic           div1_vld;
    logic [D1W-1:0] div1_q;
    logic [33:0]    div1_side_o;

    tvdlfc_div #(.DW(D1W), .VW(33), .SW(34)) u_div_ratio (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_vld_reg),
        .in_dividend  (div1_dividend),
        .in_divisor   (den_mag),
        .in_side      (div1_side),
        .out_valid    (div1_vld),
        .out_quotient (div1_q),
        .out_side     (div1_side_o)
    );

    // Ratio minus one, saturated.
    logic signed [RW-1:0] q1_s;
    logic signed [RW-1:0] r_wide;
    logic signed [31:0]   r_next;
    logic signed [31:0]   r_reg;
    logic signed [31:0]   flux_b_reg;
    logic                 vld_b_reg;

    always_comb
    begin
        q1_s   = div1_side_o[1] ? -RW'(div1_q) : RW'(div1_q);
        r_wide = q1_s - ONER;
        if ((&r_wide[RW-1:31]) || !(|r_wide[RW-1:31]))
        begin
            r_next = r_wide[31:0];
        end
        else
        begin
            r_next = r_wide[RW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        if (div1_side_o[0])
        begin
            r_next = 32'sd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_b_reg <= 1'b0;
        end
        else
        begin
            vld_b_reg <= div1_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg      <= r_next;
        flux_b_reg <= div1_side_o[33:2];
    end

    // First limiter quotient: muscl ratio or charm intermediate.
    logic [33:0]    charm_num;
    logic [D2W-1:0] div2_dividend;
    logic [31:0]    div2_divisor;

    always_comb
    begin
        charm_num    = 34'({2'b00, r_reg} * 34'd5) + THREE34;
        div2_divisor = r_reg + ONE32;
        if (mode_reg == tvdlfc_pkg::MODE_CHARM)
        begin
            div2_dividend = {charm_num, {F{1'b0}}};
        end
        else
        begin
            div2_dividend = {1'b0, r_reg, 1'b0, {F{1'b0}}};
        end
    end

    logic           div2_vld;
    logic [D2W-1:0] div2_q;
    logic [63:0]    div2_side_o;

    tvdlfc_div #(.DW(D2W), .VW(32), .SW(64)) u_div_lim (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (vld_b_reg),
        .in_dividend  (div2_dividend),
        .in_divisor   (div2_divisor),
        .in_side      ({flux_b_reg, r_reg}),
        .out_valid    (div2_vld),
        .out_quotient (div2_q),
        .out_side     (div2_side_o)
    );

    // Second charm quotient.
    logic [F+2:0]   q2c;
    logic [D3W-1:0] div3_dividend;
    logic [31:0]    div3_divisor;

    assign q2c           = div2_q[F+2:0];
    assign div3_dividend = {q2c, {F{1'b0}}};
    assign div3_divisor  = div2_side_o[31:0] + ONE32;

    logic           div3_vld;
    logic [D3W-1:0] div3_q;
    logic [F+66:0]  div3_side_o;

    tvdlfc_div #(.DW(D3W), .VW(32), .SW(F + 67)) u_div_charm (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (div2_vld),
        .in_dividend  (div3_dividend),
        .in_divisor   (div3_divisor),
        .in_side      ({div2_side_o, q2c}),
        .out_valid    (div3_vld),
        .out_quotient (div3_q),
        .out_side     (div3_side_o)
    );

    // Limiter selection.
    logic signed [31:0] r_d;
    logic signed [33:0] r34;
    logic signed [33:0] lim_a;
    logic signed [33:0] lim_b;
    logic signed [33:0] lim_m;
    logic [F+2:0]       q2_d;
    logic               r_pos;
    logic [PW-1:0]      phi_next;
    logic [PW-1:0]      phi_reg;
    logic signed [31:0] flux_d_reg;
    logic               vld_d_reg;

    always_comb
    begin
        r_d   = div3_side_o[F+34:F+3];
        q2_d  = div3_side_o[F+2:0];
        r34   = 34'(r_d);
        r_pos = (r_d > 32'sd0);
        lim_a = ((r34 <<< 1) < ONE34) ? (r34 <<< 1) : ONE34;
        lim_b = (r34 < TWO34) ? r34 : TWO34;
        lim_m = (r34 < ONE34) ? r34 : ONE34;
        case (mode_reg)
            tvdlfc_pkg::MODE_SUPERBEE:
            begin
                lim_m    = (lim_a > lim_b) ? lim_a : lim_b;
                phi_next = (lim_m > 34'sd0) ? lim_m[PW-1:0] : '0;
            end
            tvdlfc_pkg::MODE_MINMOD:
            begin
                phi_next = (lim_m > 34'sd0) ? lim_m[PW-1:0] : '0;
            end
            tvdlfc_pkg::MODE_OSHER:
            begin
                phi_next = (lim_b > 34'sd0) ? lim_b[PW-1:0] : '0;
            end
            tvdlfc_pkg::MODE_MUSCL:
            begin
                phi_next = r_pos ? q2_d[PW-1:0] : '0;
            end
            tvdlfc_pkg::MODE_CHARM:
            begin
                if (!r_pos || (div3_q >= THREE3))
                begin
                    phi_next = '0;
                end
                else
                begin
                    phi_next = PW'(THREE3 - div3_q);
                end
            end
            default:
            begin
                phi_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_d_reg <= 1'b0;
        end
        else
        begin
            vld_d_reg <= div3_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        phi_reg    <= phi_next;
        flux_d_reg <= div3_side_o[F+66:F+35];
    end

    // Products with the flux.
    logic signed [PW:0]   phi_s;
    logic signed [PW:0]   comp_s;
    logic signed [MW-1:0] p_nc_reg;
    logic signed [MW-1:0] p_cp_reg;
    logic                 vld_e_reg;

    assign phi_s  = $signed({1'b0, phi_reg});
    assign comp_s = TWOP - phi_s;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_e_reg <= 1'b0;
        end
        else
        begin
            vld_e_reg <= vld_d_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p_nc_reg <= MW'(flux_d_reg) * MW'(phi_s);
        p_cp_reg <= MW'(flux_d_reg) * MW'(comp_s);
    end

    // Division by two ONE toward zero and saturation.
    logic signed [MW-1:0] adj_nc;
    logic signed [MW-1:0] adj_cp;
    logic signed [SW-1:0] sh_nc;
    logic signed [SW-1:0] sh_cp;
    tvdlfc_pkg::coeff_t   res_next;
    tvdlfc_pkg::coeff_t   res_reg;
    logic                 done_reg;

    always_comb
    begin
        adj_nc = p_nc_reg[MW-1] ? p_nc_reg + RNDM : p_nc_reg;
        adj_cp = p_cp_reg[MW-1] ? p_cp_reg + RNDM : p_cp_reg;
        sh_nc  = adj_nc[MW-1:F+1];
        sh_cp  = adj_cp[MW-1:F+1];
        if ((&sh_nc[SW-1:31]) || !(|sh_nc[SW-1:31]))
        begin
            res_next.neighbour_coeff = sh_nc[31:0];
        end
        else
        begin
            res_next.neighbour_coeff = sh_nc[SW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        if ((&sh_cp[SW-1:31]) || !(|sh_cp[SW-1:31]))
        begin
            res_next.central_part = sh_cp[31:0];
        end
        else
        begin
            res_next.central_part = sh_cp[SW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vld_e_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

/* hw/rtl/tvdlfc_div.sv */
// Pipelined unsigned restoring divider, one quotient bit per stage, with a side payload.
`default_nettype none

module tvdlfc_div #(
    parameter int DW = 48,
    parameter int VW = 33,
    parameter int SW = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic [DW-1:0] in_dividend,
    input  wire logic [VW-1:0] in_divisor,
    input  wire logic [SW-1:0] in_side,
    output logic               out_valid,
    output logic [DW-1:0]      out_quotient,
    output logic [SW-1:0]      out_side
);

    logic [VW-1:0] rem_reg  [DW];
    logic [DW-1:0] dq_reg   [DW];
    logic [VW-1:0] dvs_reg  [DW];
    logic [SW-1:0] side_reg [DW];
    logic          vld_reg  [DW];

    logic [VW-1:0] rem_next  [DW];
    logic [DW-1:0] dq_next   [DW];
    logic [VW-1:0] dvs_next  [DW];
    logic [SW-1:0] side_next [DW];
    logic          vld_next  [DW];

    always_comb
    begin
        logic [VW-1:0] src_rem;
        logic [DW-1:0] src_dq;
        logic [VW:0]   trial;
        logic          ge;
        for (int k = 0; k < DW; k++)
        begin
            if (k == 0)
            begin
                src_rem      = '0;
                src_dq       = in_dividend;
                dvs_next[k]  = in_divisor;
                side_next[k] = in_side;
                vld_next[k]  = in_valid;
            end
            else
            begin
                src_rem      = rem_reg[k-1];
                src_dq       = dq_reg[k-1];
                dvs_next[k]  = dvs_reg[k-1];
                side_next[k] = side_reg[k-1];
                vld_next[k]  = vld_reg[k-1];
            end
            trial       = {src_rem, src_dq[DW-1]};
            ge          = (trial >= {1'b0, dvs_next[k]});
            rem_next[k] = ge ? VW'(trial - {1'b0, dvs_next[k]}) : trial[VW-1:0];
            dq_next[k]  = {src_dq[DW-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DW; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            for (int k = 0; k < DW; k++)
            begin
                vld_reg[k] <= vld_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < DW; k++)
        begin
            rem_reg[k]  <= rem_next[k];
            dq_reg[k]   <= dq_next[k];
            dvs_reg[k]  <= dvs_next[k];
            side_reg[k] <= side_next[k];
        end
    end

    assign out_valid    = vld_reg[DW-1];
    assign out_quotient = dq_reg[DW-1];
    assign out_side     = side_reg[DW-1];

endmodule

`default_nettype wire
